[src/mrfp_pkg.sv]
// Shared types and constants for the MSP response frame parser.
// Used by every module under src; depends on nothing.
package mrfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4d;  // 'M'
  localparam logic [7:0] CH_ARROW  = 8'h3e;  // '>'

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GPS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_M       = 3'd1,
    PH_ARROW   = 3'd2,
    PH_SIZE    = 3'd3,
    PH_CMD     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  // Summary of a completed frame, handed from the parser to the latch stage
  typedef struct packed {
    logic [7:0] command;
    logic [7:0] size;
    logic       ok;
    logic       oversize;
  } frame_t;

  typedef struct packed {
    logic [7:0] ident;
    logic [7:0] gps;
    logic [7:0] attitude;
    logic [7:0] altitude;
  } codes_t;

endpackage

[src/mrfp_parse.sv]
// Byte-level frame parser: header match, size, command, payload count, XOR.
// Depends on mrfp_pkg.
module mrfp_parse import mrfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  output logic       wr_en,
  output logic [7:0] wr_idx,
  output logic       done,
  output frame_t     frame
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      len_r   <= '0;
      cmd_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    wr_en     = 1'b0;
    done      = 1'b0;
    case (phase_r)
      PH_M: begin
        phase_nxt = (rx_byte == CH_M) ? PH_ARROW :
                    (rx_byte == CH_DOLLAR) ? PH_M : PH_SEARCH;
      end
      PH_ARROW: begin
        phase_nxt = (rx_byte == CH_ARROW) ? PH_SIZE :
                    (rx_byte == CH_DOLLAR) ? PH_M : PH_SEARCH;
      end
      PH_SIZE: begin
        len_nxt   = rx_byte;
        xor_nxt   = rx_byte;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        cnt_nxt   = '0;
        phase_nxt = (len_r == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // bytes past MAX_PAYLOAD are not written but still go into the checksum
        wr_en     = acc && (cnt_r < 8'(MAX_PAYLOAD));
        xor_nxt   = xor_r ^ rx_byte;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_nxt >= len_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        done      = acc;
        phase_nxt = PH_SEARCH;
      end
      default: begin
        phase_nxt = (rx_byte == CH_DOLLAR) ? PH_M : PH_SEARCH;
      end
    endcase
  end

  assign wr_idx         = cnt_r;
  assign frame.command  = cmd_r;
  assign frame.size     = len_r;
  assign frame.ok       = (xor_r == rx_byte);
  assign frame.oversize = (len_r > 8'(MAX_PAYLOAD));

endmodule

[src/mrfp_store.sv]
// Payload memory: four byte lanes per row, one byte written per cycle,
// row 0 read into a register on rd_en. Depends on mrfp_pkg.
module mrfp_store import mrfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [7:0]       wr_idx,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  output logic [3:0][7:0]  rd_data
);

  localparam int ROWS  = (MAX_PAYLOAD + 3) / 4;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [3:0][7:0] mem [ROWS];
  logic [3:0][7:0] rd_data_r;
  logic [5:0]      row_full;
  logic [ROW_W-1:0] wr_row;

  assign row_full = wr_idx[7:2];
  assign wr_row   = row_full[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_idx[1:0]] <= wr_data;
    end
  end

  // Only the first four payload bytes carry telemetry fields
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[0];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/mrfp_latch.sv]
// Frame completion stage: telemetry decode from payload row 0, latched
// telemetry registers and the output register. Depends on mrfp_pkg.
module mrfp_latch import mrfp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                done,
  input  frame_t              frame,
  input  codes_t              codes,
  input  logic [3:0][7:0]     rd_data,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output frame_t              out_frame,
  output logic [7:0]          version,
  output logic signed [15:0]  home_distance,
  output logic signed [15:0]  home_direction,
  output logic signed [15:0]  pitch,
  output logic signed [15:0]  roll,
  output logic signed [31:0]  altitude
);

  logic   p_valid_r, p_valid_nxt;
  frame_t p_frame_r;
  logic   o_valid_r, o_valid_nxt;
  frame_t o_frame_r;
  logic   p_adv;

  logic [7:0]  ver_r;
  logic [15:0] dist_r, dir_r, pitch_r, roll_r;
  logic [31:0] alt_r;

  logic hit_ident, hit_gps, hit_att, hit_alt;
  logic [15:0] lo16, hi16;

  assign p_adv    = p_valid_r && (!o_valid_r || !out_stall);
  // Hold the input while a finished frame cannot move on
  assign in_stall = p_valid_r && !p_adv;

  assign p_valid_nxt = done || (p_valid_r && !p_adv);
  assign o_valid_nxt = p_adv || (o_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      p_frame_r <= frame;
    end
    if (p_adv) begin
      o_frame_r <= p_frame_r;
    end
  end

  // First matching code wins: ident, gps, attitude, altitude
  assign hit_ident = p_frame_r.ok && (p_frame_r.command == codes.ident);
  assign hit_gps   = p_frame_r.ok && !hit_ident && (p_frame_r.command == codes.gps);
  assign hit_att   = p_frame_r.ok && !hit_ident && !hit_gps &&
                     (p_frame_r.command == codes.attitude);
  assign hit_alt   = p_frame_r.ok && !hit_ident && !hit_gps && !hit_att &&
                     (p_frame_r.command == codes.altitude);
  assign lo16      = {rd_data[1], rd_data[0]};
  assign hi16      = {rd_data[3], rd_data[2]};

  // Telemetry changes only as a frame moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r   <= '0;
      dist_r  <= '0;
      dir_r   <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
      alt_r   <= '0;
    end else if (p_adv) begin
      if (hit_ident && p_frame_r.size >= 8'd1) begin
        ver_r <= rd_data[0];
      end
      if (hit_gps && p_frame_r.size >= 8'd2) begin
        dist_r <= lo16;
      end
      if (hit_gps && p_frame_r.size >= 8'd4) begin
        dir_r <= hi16;
      end
      if (hit_att && p_frame_r.size >= 8'd2) begin
        roll_r <= lo16;
      end
      if (hit_att && p_frame_r.size >= 8'd4) begin
        pitch_r <= hi16;
      end
      if (hit_alt && p_frame_r.size >= 8'd4) begin
        alt_r <= {hi16, lo16};
      end
    end
  end

  assign out_valid      = o_valid_r;
  assign out_frame      = o_frame_r;
  assign version        = ver_r;
  assign home_distance  = dist_r;
  assign home_direction = dir_r;
  assign pitch          = pitch_r;
  assign roll           = roll_r;
  assign altitude       = alt_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (o_valid_r && out_stall))
    else $error("input held without output back-pressure");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !p_adv) |=> (p_valid_r && $stable(p_frame_r)))
    else $error("pending frame lost while blocked");

  a_no_done_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !done)
    else $error("frame completed while latch stage blocked");

  a_telem_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !p_adv |=> ($stable(alt_r) && $stable(ver_r) && $stable(roll_r)))
    else $error("telemetry changed without a frame transfer");

endmodule

[src/msp_response_frame_parser_unit.sv]
// Top level of the MSP response frame parser: configuration registers and
// the parse / payload memory / latch pipeline. Depends on mrfp_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  in      | in_rx_byte                              | in_valid / in_stall
//  out     | out_frame_command .. out_altitude       | out_valid / out_stall
//  cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
//  One byte is accepted per cycle unless in_stall is high; the parser state
//  steps once per byte taken. The checksum byte loads the pending frame and the
//  row 0 memory read; the telemetry decode then loads the output register.
//  in_stall rises only while a completed frame waits behind a stalled output.
//  Reset is synchronous; the payload memory needs no clearing pass.
module msp_response_frame_parser_unit import mrfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_frame_command,
  output logic [7:0]           out_frame_size,
  output logic                 out_checksum_ok,
  output logic                 out_oversize,
  output logic [7:0]           out_version,
  output logic signed [15:0]   out_home_distance,
  output logic signed [15:0]   out_home_direction,
  output logic signed [15:0]   out_pitch,
  output logic signed [15:0]   out_roll,
  output logic signed [31:0]   out_altitude,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  codes_t          codes_r;
  logic            acc;
  logic            wr_en;
  logic [7:0]      wr_idx;
  logic            done;
  frame_t          frame;
  frame_t          out_frame;
  logic [3:0][7:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.ident    <= 8'd100;
      codes_r.gps      <= 8'd107;
      codes_r.attitude <= 8'd108;
      codes_r.altitude <= 8'd109;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDENT:    codes_r.ident    <= cfg_wdata;
        CFG_GPS:      codes_r.gps      <= cfg_wdata;
        CFG_ATTITUDE: codes_r.attitude <= cfg_wdata;
        CFG_ALTITUDE: codes_r.altitude <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign acc = in_valid && !in_stall;

  mrfp_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .done    (done),
    .frame   (frame)
  );

  mrfp_store #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (in_rx_byte),
    .rd_en   (done),
    .rd_data (rd_data)
  );

  mrfp_latch u_latch (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .frame          (frame),
    .codes          (codes_r),
    .rd_data        (rd_data),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame      (out_frame),
    .version        (out_version),
    .home_distance  (out_home_distance),
    .home_direction (out_home_direction),
    .pitch          (out_pitch),
    .roll           (out_roll),
    .altitude       (out_altitude)
  );

  assign out_frame_command = out_frame.command;
  assign out_frame_size    = out_frame.size;
  assign out_checksum_ok   = out_frame.ok;
  assign out_oversize      = out_frame.oversize;

endmodule
